/* rtl/wdq_pkg.sv */
// Shared types and constants of the work dispatch queue.
package wdq_pkg;

    localparam int unsigned MAX_PROCS  = 16;
    localparam int unsigned WAIT_AW    = 4;
    localparam int unsigned WAIT_FW    = 5;
    localparam int unsigned DESC_WIDTH = 32;
    localparam int unsigned SRC_W      = 4;
    localparam int unsigned QLEN_W     = 7;
    localparam int unsigned QNUM_W     = 32;
    localparam int unsigned CNT_W      = 5;

    // Operation codes
    localparam logic [1:0] OP_INFO_RQST = 2'd0;
    localparam logic [1:0] OP_WORK_SEND = 2'd1;
    localparam logic [1:0] OP_WORK_RQST = 2'd2;
    localparam logic [1:0] OP_END       = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_INFO     = 2'd0;
    localparam logic [1:0] KIND_DELIVER  = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [SRC_W-1:0]      source;
        logic [DESC_WIDTH-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [SRC_W-1:0]      dest;
        logic [DESC_WIDTH-1:0] work_desc;
        logic [QLEN_W-1:0]     queue_length;
        logic [QNUM_W-1:0]     query_number;
        logic                  last;
    } rsp_t;

endpackage

/* rtl/work_dispatch_queue.sv */
// Work dispatch queue: work and idle-worker FIFOs in memory, end-notice sequencer.
//
//  channel | signals                       | role
//  --------+-------------------------------+-----------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd     | op / source / payload in
//  rsp     | rsp_valid, rsp_stall, rsp     | kind / dest / desc / info out
//  cfg     | cfg_valid, cfg_ready, cfg_data| process_count write, always ready
//
// An item passes through the accept cycle, in which both FIFO memories
// register the word at their head, and a read-modify-write cycle that
// updates the heads, fill counts and memory tails. The end sequence then
// sends one end notice per cycle unless rsp stalls, process_count - 1 of them.
// A stall on rsp holds the execute cycle until the output register frees up.
// No clearing pass after reset: only entries within the fill counts are ever read.
module work_dispatch_queue #(
    parameter int unsigned WORK_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  wdq_pkg::cmd_t             cmd,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output wdq_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [wdq_pkg::CNT_W-1:0] cfg_data
);
    import wdq_pkg::*;

    localparam int unsigned WORK_AW = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;
    localparam int unsigned WORK_FW = $clog2(WORK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_END  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Storage
    logic [DESC_WIDTH-1:0] work_mem [WORK_DEPTH];
    logic [SRC_W-1:0]      wait_mem [MAX_PROCS];

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [WORK_AW-1:0]    work_head_reg, work_head_next;
    logic [WORK_FW-1:0]    work_fill_reg, work_fill_next;
    logic [WAIT_AW-1:0]    wait_head_reg, wait_head_next;
    logic [WAIT_FW-1:0]    wait_fill_reg, wait_fill_next;
    logic [QNUM_W-1:0]     qnum_reg, qnum_next;
    logic [CNT_W-1:0]      pcount_reg;
    logic [SRC_W-1:0]      end_id_reg, end_id_next;
    logic [DESC_WIDTH-1:0] work_rd_reg;
    logic [SRC_W-1:0]      wait_rd_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    // Memory write controls
    logic                  work_we;
    logic [WORK_AW-1:0]    work_waddr;
    logic                  wait_we;
    logic [WAIT_AW-1:0]    wait_waddr;

    logic                  cmd_xfer;
    logic                  rsp_free;
    logic                  rsp_load;
    logic [CNT_W-1:0]      count_eff;
    logic [CNT_W-1:0]      count_m1;
    logic [WORK_AW:0]      work_tail_sum;
    logic [WORK_AW-1:0]    work_tail;
    logic [WORK_AW-1:0]    work_head_inc;
    logic [WAIT_FW-1:0]    wait_fill_q;
    logic                  end_last;

    assign cmd_stall = !((state_reg == ST_IDLE) || (state_reg == ST_DONE));
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Clamp the process count to the supported range.
    always_comb
    begin
        priority if (pcount_reg < CNT_W'(2))
        begin
            count_eff = CNT_W'(2);
        end
        else if (pcount_reg > CNT_W'(MAX_PROCS))
        begin
            count_eff = CNT_W'(MAX_PROCS);
        end
        else
        begin
            count_eff = pcount_reg;
        end
    end
    assign count_m1 = count_eff - CNT_W'(1);
    assign end_last = ({1'b0, end_id_reg} == count_m1);

    // Tail of the work ring: head plus fill, wrapped once.
    always_comb
    begin
        work_tail_sum = (WORK_AW + 1)'(work_head_reg) + (WORK_AW + 1)'(work_fill_reg);
        if (work_tail_sum >= (WORK_AW + 1)'(WORK_DEPTH))
        begin
            work_tail_sum = work_tail_sum - (WORK_AW + 1)'(WORK_DEPTH);
        end
        work_tail = work_tail_sum[WORK_AW-1:0];
    end
    assign work_head_inc = (work_head_reg == WORK_AW'(WORK_DEPTH - 1)) ?
                           '0 : work_head_reg + WORK_AW'(1);

    // Waiter fill after queuing the requester; a full queue drops the id.
    assign wait_fill_q = (wait_fill_reg < WAIT_FW'(MAX_PROCS)) ?
                         wait_fill_reg + WAIT_FW'(1) : wait_fill_reg;

    always_comb
    begin
        state_next     = state_reg;
        work_head_next = work_head_reg;
        work_fill_next = work_fill_reg;
        wait_head_next = wait_head_reg;
        wait_fill_next = wait_fill_reg;
        qnum_next      = qnum_reg;
        end_id_next    = end_id_reg;
        rsp_load       = 1'b0;
        rsp_next       = '0;
        work_we        = 1'b0;
        work_waddr     = work_tail;
        wait_we        = 1'b0;
        wait_waddr     = wait_head_reg + wait_fill_reg[WAIT_AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold until the output register can take a result.
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                    unique case (cmd_reg.op)
                        OP_INFO_RQST:
                        begin
                            rsp_load              = 1'b1;
                            rsp_next.kind         = KIND_INFO;
                            rsp_next.dest         = cmd_reg.source;
                            rsp_next.queue_length = QLEN_W'(work_fill_reg);
                            rsp_next.query_number = qnum_reg;
                            rsp_next.last         = 1'b1;
                            qnum_next             = qnum_reg + QNUM_W'(1);
                        end
                        OP_WORK_SEND:
                        begin
                            priority if (wait_fill_reg != '0)
                            begin
                                // Hand straight to the oldest waiting worker.
                                rsp_load           = 1'b1;
                                rsp_next.kind      = KIND_DELIVER;
                                rsp_next.dest      = wait_rd_reg;
                                rsp_next.work_desc = cmd_reg.payload;
                                rsp_next.last      = 1'b1;
                                wait_head_next     = wait_head_reg + WAIT_AW'(1);
                                wait_fill_next     = wait_fill_reg - WAIT_FW'(1);
                            end
                            else if (work_fill_reg == WORK_FW'(WORK_DEPTH))
                            begin
                                // Drop the descriptor and flag overflow.
                                rsp_load      = 1'b1;
                                rsp_next.kind = KIND_OVERFLOW;
                                rsp_next.dest = cmd_reg.source;
                                rsp_next.last = 1'b1;
                            end
                            else
                            begin
                                work_we        = 1'b1;
                                work_fill_next = work_fill_reg + WORK_FW'(1);
                            end
                        end
                        OP_WORK_RQST:
                        begin
                            if (work_fill_reg != '0)
                            begin
                                rsp_load           = 1'b1;
                                rsp_next.kind      = KIND_DELIVER;
                                rsp_next.dest      = cmd_reg.source;
                                rsp_next.work_desc = work_rd_reg;
                                rsp_next.last      = 1'b1;
                                work_head_next     = work_head_inc;
                                work_fill_next     = work_fill_reg - WORK_FW'(1);
                            end
                            else
                            begin
                                wait_we        = (wait_fill_reg < WAIT_FW'(MAX_PROCS));
                                wait_fill_next = wait_fill_q;
                                if (wait_fill_q >= count_m1)
                                begin
                                    state_next  = ST_END;
                                    end_id_next = SRC_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // Unused op: drop it.
                        end
                    endcase
                end
            end
            ST_END:
            begin
                if (rsp_free)
                begin
                    rsp_load      = 1'b1;
                    rsp_next.kind = KIND_END;
                    rsp_next.dest = end_id_reg;
                    rsp_next.last = end_last;
                    if (end_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        end_id_next = end_id_reg + SRC_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                // Swallow every transfer until reset.
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_head_reg <= '0;
            work_fill_reg <= '0;
            wait_head_reg <= '0;
            wait_fill_reg <= '0;
            qnum_reg      <= '0;
            pcount_reg    <= CNT_W'(MAX_PROCS);
            end_id_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_head_reg <= work_head_next;
            work_fill_reg <= work_fill_next;
            wait_head_reg <= wait_head_next;
            wait_fill_reg <= wait_fill_next;
            qnum_reg      <= qnum_next;
            end_id_reg    <= end_id_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                pcount_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            cmd_reg <= cmd;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Memories: read the heads every cycle, write the tails on enqueue.
    // The execute cycle always follows an accept cycle, so the registered
    // head words already reflect the previous item's updates.
    always_ff @(posedge clk)
    begin
        work_rd_reg <= work_mem[work_head_reg];
        if (work_we)
        begin
            work_mem[work_waddr] <= cmd_reg.payload;
        end
    end

    always_ff @(posedge clk)
    begin
        wait_rd_reg <= wait_mem[wait_head_reg];
        if (wait_we)
        begin
            wait_mem[wait_waddr] <= cmd_reg.source;
        end
    end

    // Checks
    a_work_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        work_fill_reg <= WORK_FW'(WORK_DEPTH))
        else $error("work fill exceeds depth");

    a_wait_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wait_fill_reg <= WAIT_FW'(MAX_PROCS))
        else $error("waiter fill exceeds depth");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (state_reg == ST_DONE))
        else $error("left done state");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (rsp_free && ((state_reg == ST_EXEC) || (state_reg == ST_END))))
        else $error("result loaded over a pending result");

endmodule

/* dv/wdq_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the work dispatch queue: tracks its queues and checks each result.
module wdq_checker #(
    parameter int unsigned WORK_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  logic                      cmd_stall,
    input  wdq_pkg::cmd_t             cmd,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  wdq_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [wdq_pkg::CNT_W-1:0] cfg_data,
    output int unsigned               fail_count,
    output int unsigned               pending,
    output int unsigned               checked
);
    import wdq_pkg::*;

    logic [DESC_WIDTH-1:0] work_descs [WORK_DEPTH];
    int unsigned           work_head;
    int unsigned           work_fill;
    logic [SRC_W-1:0]      waiter_ids [MAX_PROCS];
    int unsigned           waiter_head;
    int unsigned           waiter_fill;
    logic [QNUM_W-1:0]     query_ctr;
    logic [CNT_W-1:0]      proc_count;
    logic                  halted;
    rsp_t                  due_rsps [$];

    function automatic rsp_t pack_rsp(
        input logic [1:0]            kind,
        input logic [SRC_W-1:0]      dest,
        input logic [DESC_WIDTH-1:0] desc,
        input logic [QLEN_W-1:0]     qlen,
        input logic [QNUM_W-1:0]     qnum,
        input logic                  last
    );
        rsp_t r;
        r.kind         = kind;
        r.dest         = dest;
        r.work_desc    = desc;
        r.queue_length = qlen;
        r.query_number = qnum;
        r.last         = last;
        return r;
    endfunction

    // Append one result to the list of results still due.
    function automatic void add_due(input rsp_t r);
        due_rsps.insert(due_rsps.size(), r);
    endfunction

    // Advance the dispatcher state by one command and queue the results it causes.
    task automatic predict_dispatch(input cmd_t c);
        int unsigned eff;
        int unsigned id;
        if (!halted)
        begin
            case (c.op)
                OP_INFO_RQST:
                begin
                    add_due(pack_rsp(KIND_INFO, c.source, '0,
                                     QLEN_W'(work_fill), query_ctr, 1'b1));
                    query_ctr = query_ctr + 1'b1;
                end
                OP_WORK_SEND:
                begin
                    if (waiter_fill != 0)
                    begin
                        add_due(pack_rsp(KIND_DELIVER, waiter_ids[waiter_head],
                                         c.payload, '0, '0, 1'b1));
                        waiter_head = (waiter_head + 1) % MAX_PROCS;
                        waiter_fill--;
                    end
                    else if (work_fill >= WORK_DEPTH)
                    begin
                        add_due(pack_rsp(KIND_OVERFLOW, c.source, '0, '0, '0, 1'b1));
                    end
                    else
                    begin
                        work_descs[(work_head + work_fill) % WORK_DEPTH] = c.payload;
                        work_fill++;
                    end
                end
                OP_WORK_RQST:
                begin
                    if (work_fill != 0)
                    begin
                        add_due(pack_rsp(KIND_DELIVER, c.source,
                                         work_descs[work_head], '0, '0, 1'b1));
                        work_head = (work_head + 1) % WORK_DEPTH;
                        work_fill--;
                    end
                    else
                    begin
                        if (waiter_fill < MAX_PROCS)
                        begin
                            waiter_ids[(waiter_head + waiter_fill) % MAX_PROCS] = c.source;
                            waiter_fill++;
                        end
                        eff = (proc_count < 2) ? 2 :
                              (proc_count > MAX_PROCS) ? MAX_PROCS : proc_count;
                        // every worker idle: broadcast the end notice and stop
                        if (waiter_fill >= eff - 1)
                        begin
                            for (id = 1; id < eff; id++)
                            begin
                                add_due(pack_rsp(KIND_END, SRC_W'(id), '0, '0, '0,
                                                 id == eff - 1));
                            end
                            halted = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        checked++;
        if (due_rsps.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("wdq_chk: unexpected result kind=%0d dest=%0d desc=%h",
                         got.kind, got.dest, got.work_desc);
        end
        else
        begin
            want = due_rsps.pop_front();
            if (got.kind !== want.kind || got.dest !== want.dest ||
                got.work_desc !== want.work_desc || got.queue_length !== want.queue_length ||
                got.query_number !== want.query_number || got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display({"wdq_chk: result %0d exp kind=%0d dest=%0d desc=%h",
                              " qlen=%0d qnum=%0d last=%0d"},
                             checked, want.kind, want.dest, want.work_desc,
                             want.queue_length, want.query_number, want.last);
                    $display({"wdq_chk: result %0d got kind=%0d dest=%0d desc=%h",
                              " qlen=%0d qnum=%0d last=%0d"},
                             checked, got.kind, got.dest, got.work_desc,
                             got.queue_length, got.query_number, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_head   = 0;
            work_fill   = 0;
            waiter_head = 0;
            waiter_fill = 0;
            query_ctr   = '0;
            proc_count  = CNT_W'(16);
            halted      = 1'b0;
            fail_count  = 0;
            checked     = 0;
            due_rsps.delete();
        end
        else
        begin
            // a result never belongs to the command taken at the same edge
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (cfg_valid && cfg_ready)
                proc_count = cfg_data;
            if (cmd_valid && !cmd_stall)
                predict_dispatch(cmd);
        end
        pending = due_rsps.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the work dispatch queue: stimulus, flow control and verdict.
module tb;
    import wdq_pkg::*;

    localparam int unsigned WORK_DEPTH    = 64;
    localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int unsigned SETTLE_CYCLES = 20;    // lets a result-less command finish executing
    localparam int unsigned HOLD_CYCLES   = 300;

    typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    cmd_t             cmd       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    int unsigned chk_fails;
    int unsigned chk_pending;
    int unsigned chk_checked;

    // Stimulus-side bookkeeping: just enough to steer clear of an early end broadcast.
    int unsigned sh_work    = 0;
    int unsigned sh_waiters = 0;
    int unsigned eff_count  = 16;
    logic        sh_done    = 1'b0;
    int unsigned cmds_sent  = 0;
    int unsigned cfg_writes = 0;

    logic        calm     = 1'b0;  // no idling on either side while set
    logic        rsp_hold = 1'b0;
    int unsigned rsp_gap  = 0;
    int unsigned rsp_next_gap;
    int unsigned quiet_cycles = 0;

    work_dispatch_queue #(
        .WORK_DEPTH (WORK_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wdq_checker #(
        .WORK_DEPTH (WORK_DEPTH)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (chk_fails),
        .pending    (chk_pending),
        .checked    (chk_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: after each transfer, draw a random stall, possibly none;
    // the long hold overrides everything while it lasts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap   <= 0;
        end
        else if (rsp_hold)
        begin
            rsp_stall <= 1'b1;
        end
        else if (rsp_gap != 0)
        begin
            rsp_gap   <= rsp_gap - 1;
            rsp_stall <= 1'b1;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            rsp_next_gap = calm ? 0 : $urandom_range(0, 8);
            rsp_stall <= (rsp_next_gap != 0);
            rsp_gap   <= (rsp_next_gap > 1) ? rsp_next_gap - 1 : 0;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if no channel makes a transfer for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: no transfer for %0d cycles, %0d results still due",
                     QUIET_LIMIT, chk_pending);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [SRC_W-1:0] src,
                                    input logic [DESC_WIDTH-1:0] payload);
        cmd_t c;
        c.op      = op;
        c.source  = src;
        c.payload = payload;
        return c;
    endfunction

    // Offer one command and hold it until the transfer. Leave valid high so
    // a back-to-back command needs no second assignment in the same step.
    task automatic send_cmd(input cmd_t c);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        cmds_sent++;
        // track the queue depths to keep the end broadcast for the last phase
        if (!sh_done)
        begin
            case (c.op)
                OP_WORK_SEND:
                begin
                    if (sh_waiters != 0)
                        sh_waiters--;
                    else if (sh_work < WORK_DEPTH)
                        sh_work++;
                end
                OP_WORK_RQST:
                begin
                    if (sh_work != 0)
                    begin
                        sh_work--;
                    end
                    else
                    begin
                        sh_waiters++;
                        if (sh_waiters + 1 >= eff_count)
                            sh_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endtask

    // Drop valid right at the last transfer of a burst.
    task automatic close_cmd();
        cmd_valid <= 1'b0;
    endtask

    // Write process_count once the block has drained, then track its clamped value.
    task automatic write_proc_count(input logic [CNT_W-1:0] value);
        while (chk_pending != 0) @(negedge clk);
        // a queued submit leaves no result behind, so let the pipeline settle too
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        eff_count = (value < 2) ? 2 : (value > MAX_PROCS) ? MAX_PROCS : value;
    endtask

    // Random commands; ignored opcodes do not count toward n.
    task automatic random_phase(input int unsigned n, input mix_t mix);
        int unsigned sub_pct;
        int unsigned roll;
        int unsigned counted;
        cmd_t        c;
        sub_pct = (mix == MIX_FILL) ? 95 : (mix == MIX_DRAIN) ? 10 : 45;
        counted = 0;
        while (counted < n)
        begin
            roll      = $urandom_range(0, 99);
            c.source  = $urandom_range(0, 15);
            c.payload = $urandom();
            if (roll < 3)
                c.op = OP_END;
            else if (roll < 15)
                c.op = OP_INFO_RQST;
            else if ($urandom_range(0, 99) < sub_pct)
                c.op = OP_WORK_SEND;
            else
                c.op = OP_WORK_RQST;
            // a request that would queue the last idle worker becomes a submit
            if (c.op == OP_WORK_RQST && sh_work == 0 && sh_waiters + 2 >= eff_count)
                c.op = OP_WORK_SEND;
            send_cmd(c);
            if (c.op != OP_END)
                counted++;
        end
        close_cmd();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: info at reset, ignored opcode, waiting workers served by
        // submits, queued work served by requests, extreme ids and payloads.
        send_cmd(mk_cmd(OP_INFO_RQST, 4'd0, 32'h0000_0000));
        send_cmd(mk_cmd(OP_END, 4'd5, 32'h1234_5678));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'd15, 32'h0000_0000));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'd0, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'd3, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'd12, 32'h0000_0000));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'd0, 32'hA5A5_5A5A));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'd15, 32'h0000_0001));
        send_cmd(mk_cmd(OP_INFO_RQST, 4'd15, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'd7, 32'h0000_0000));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'd8, 32'h0000_0000));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'd1, 32'h0000_0000));
        send_cmd(mk_cmd(OP_INFO_RQST, 4'd8, 32'h0000_0000));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'd9, 32'h8000_0000));
        send_cmd(mk_cmd(OP_END, 4'd15, 32'hFFFF_FFFF));
        close_cmd();

        // Smallest count: any queued request would end the run, so only
        // requests that find work get through.
        write_proc_count(CNT_W'(2));
        random_phase(15, MIX_EVEN);

        // Below range, acts as two; no idling on either side here.
        write_proc_count(CNT_W'(0));
        calm = 1'b1;
        random_phase(15, MIX_EVEN);
        calm = 1'b0;

        // Above range, acts as the maximum; push the work queue into overflow.
        write_proc_count(CNT_W'(31));
        random_phase(100, MIX_FILL);

        // Drain the work queue, then let workers pile up under a random count.
        write_proc_count(CNT_W'(1));
        random_phase(40, MIX_DRAIN);
        write_proc_count(CNT_W'($urandom_range(3, 15)));
        random_phase(30, MIX_DRAIN);

        // Hold off the result side for a long stretch while commands keep coming,
        // so the block backs up and stalls its input.
        write_proc_count(CNT_W'(17));
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold <= 1'b0;
            end
            random_phase(25, MIX_EVEN);
        join

        // Largest count: drain remaining work, then queue workers until every
        // one waits and the full end broadcast goes out.
        write_proc_count(CNT_W'(16));
        random_phase(15, MIX_EVEN);
        while (!sh_done)
            send_cmd(mk_cmd(OP_WORK_RQST, 4'($urandom_range(0, 15)), $urandom()));
        // once done, the block ignores everything
        send_cmd(mk_cmd(OP_INFO_RQST, 4'($urandom_range(0, 15)), $urandom()));
        send_cmd(mk_cmd(OP_WORK_SEND, 4'($urandom_range(0, 15)), $urandom()));
        send_cmd(mk_cmd(OP_WORK_RQST, 4'($urandom_range(0, 15)), $urandom()));
        send_cmd(mk_cmd(OP_END, 4'($urandom_range(0, 15)), $urandom()));
        close_cmd();

        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d commands over %0d process_count writes, %0d results checked",
                 cmds_sent, cfg_writes, chk_checked);
        $display("tb: covered overflow, result back-pressure, clamped counts, end broadcast");
        if (chk_fails == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
